// ===== rtl/core/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared constants and types for the two-class priority ticket queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

  localparam int QueueDepthDefault = 16;
  localparam int TicketsDefault    = 10;

  localparam int TagW    = 16;
  localparam int AgeW    = 7;
  localparam int StatusW = 2;

  localparam logic [AgeW-1:0] ThresholdReset = 7'd65;

  typedef logic [StatusW-1:0] status_t;

  localparam status_t StIssued = 2'd0;
  localparam status_t StServed = 2'd1;
  localparam status_t StEmpty  = 2'd2;
  localparam status_t StFull   = 2'd3;

  localparam logic ReqArrival = 1'b0;
  localparam logic ReqCall    = 1'b1;

  localparam logic ClassRegular  = 1'b0;
  localparam logic ClassPriority = 1'b1;

  // Command from the decision stage to one class queue.
  typedef struct packed {
    logic push;
    logic pop;
  } queue_cmd_t;

  // Occupancy flags reported by one class queue.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcpq_ram.sv =====
// ----------------------------------------------------------------------------
// tcpq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/tcpq_class_queue.sv =====
// ----------------------------------------------------------------------------
// tcpq_class_queue
// One service class: FIFO pointers and count, the class ticket counter and
// the entry RAM holding tag and ticket of each waiting client.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_class_queue #(
  parameter int DEPTH   = tcpq_pkg::QueueDepthDefault,
  parameter int TICKETS = tcpq_pkg::TicketsDefault,
  localparam int TicketW = $clog2(TICKETS)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire tcpq_pkg::queue_cmd_t      cmd,
  input  wire logic [tcpq_pkg::TagW-1:0] push_tag,
  output tcpq_pkg::queue_stat_t          stat,
  output logic      [TicketW-1:0]        ticket,
  output logic      [tcpq_pkg::TagW-1:0] pop_tag,
  output logic      [TicketW-1:0]        pop_ticket
);

  localparam int PtrW   = $clog2(DEPTH);
  localparam int CntW   = $clog2(DEPTH + 1);
  localparam int EntryW = tcpq_pkg::TagW + TicketW;

  logic [PtrW-1:0]    head_r, head_nxt;
  logic [PtrW-1:0]    tail_r, tail_nxt;
  logic [CntW-1:0]    count_r, count_nxt;
  logic [TicketW-1:0] ticket_r, ticket_nxt;
  logic [EntryW-1:0]  rd_entry;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    ticket_nxt = ticket_r;
    if (cmd.push) begin
      tail_nxt  = (tail_r == PtrW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
      // Tickets count from 0 up to TICKETS - 1 and then wrap to 0.
      ticket_nxt = (ticket_r == TicketW'(TICKETS - 1)) ? '0 : ticket_r + 1'b1;
    end
    if (cmd.pop) begin
      head_nxt  = (head_r == PtrW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      ticket_r <= '0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      ticket_r <= ticket_nxt;
    end
  end

  tcpq_ram #(
    .WIDTH (EntryW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (tail_r),
    .wdata ({push_tag, ticket_r}),
    .re    (cmd.pop),
    .raddr (head_r),
    .rdata (rd_entry)
  );

  assign stat.full  = (count_r == CntW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign ticket     = ticket_r;
  assign pop_tag    = rd_entry[EntryW-1:TicketW];
  assign pop_ticket = rd_entry[TicketW-1:0];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(DEPTH))
    else $error("class queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> count_r != '0)
    else $error("pop from an empty class queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> count_r != CntW'(DEPTH))
    else $error("push into a full class queue");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push && !cmd.pop |=> count_r == $past(count_r) + 1'b1)
    else $error("count did not advance after a push");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/two_class_priority_ticket_queue.sv =====
// ----------------------------------------------------------------------------
// two_class_priority_ticket_queue
// Strict-priority ticket queue with a priority and a regular client class.
// ----------------------------------------------------------------------------
// Usage:
//   A request is transferred at a rising edge with start high and busy low.
//   in_req_type selects an arrival (age and tag used) or a call (both
//   ignored). Every request gives exactly one result, shown on the out_
//   ports for one cycle with out_valid high; the receiver cannot stall.
//   Arrivals at or above the configured age threshold join the priority
//   class, others the regular class; each class issues tickets that wrap
//   after the last ticket number. A call serves the priority class first.
//   A full class drops the arrival (status queue full, ticket 0); a call
//   with both classes empty reports no clients waiting.
//   A request passes the input register, then the decision stage, which
//   loads the result register (out_valid) and the RAM read register.
//   Throughput: one request per cycle while busy is low, set by the single
//   decision stage and the registered read of each class RAM.
//   Reset clears both classes, the ticket counters and the threshold
//   (back to 65); busy is high during reset and drops in the cycle after it.
//   cfg_we writes cfg_wdata into the threshold; the user must do so only
//   while no request is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_priority_ticket_queue #(
  parameter int QUEUE_DEPTH       = tcpq_pkg::QueueDepthDefault,
  parameter int TICKETS_PER_CLASS = tcpq_pkg::TicketsDefault,
  localparam int TicketW = $clog2(TICKETS_PER_CLASS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_req_type,
  input  wire logic [tcpq_pkg::AgeW-1:0]    in_client_age,
  input  wire logic [tcpq_pkg::TagW-1:0]    in_client_tag,
  output logic                              out_valid,
  output logic      [tcpq_pkg::StatusW-1:0] out_status,
  output logic                              out_queue_class,
  output logic      [TicketW-1:0]           out_ticket_number,
  output logic      [tcpq_pkg::TagW-1:0]    out_served_tag,
  input  wire logic                         cfg_we,
  input  wire logic [tcpq_pkg::AgeW-1:0]    cfg_wdata
);

  logic                      busy_r;
  logic [tcpq_pkg::AgeW-1:0] threshold_r;

  // Input register.
  logic                      req_valid_r;
  logic                      req_type_r;
  logic [tcpq_pkg::AgeW-1:0] req_age_r;
  logic [tcpq_pkg::TagW-1:0] req_tag_r;

  // Result register.
  logic                      res_valid_r;
  tcpq_pkg::status_t         res_status_r, res_status_nxt;
  logic                      res_class_r, res_class_nxt;
  logic [TicketW-1:0]        res_ticket_r, res_ticket_nxt;
  logic [tcpq_pkg::TagW-1:0] res_tag_r, res_tag_nxt;
  logic                      res_pop_r, res_pop_nxt;

  tcpq_pkg::queue_cmd_t      prio_cmd, reg_cmd;
  tcpq_pkg::queue_stat_t     prio_stat, reg_stat;
  logic [TicketW-1:0]        prio_ticket, reg_ticket;
  logic [tcpq_pkg::TagW-1:0] prio_pop_tag, reg_pop_tag;
  logic [TicketW-1:0]        prio_pop_ticket, reg_pop_ticket;
  logic                      is_prio;

  assign is_prio = (req_age_r >= threshold_r);

  always_comb begin
    prio_cmd       = '0;
    reg_cmd        = '0;
    res_status_nxt = tcpq_pkg::StEmpty;
    res_class_nxt  = tcpq_pkg::ClassRegular;
    res_ticket_nxt = '0;
    res_tag_nxt    = '0;
    res_pop_nxt    = 1'b0;
    if (req_valid_r) begin
      priority if (req_type_r == tcpq_pkg::ReqArrival) begin
        res_class_nxt = is_prio ? tcpq_pkg::ClassPriority : tcpq_pkg::ClassRegular;
        res_tag_nxt   = req_tag_r;
        if (is_prio ? prio_stat.full : reg_stat.full) begin
          res_status_nxt = tcpq_pkg::StFull;
        end else begin
          res_status_nxt = tcpq_pkg::StIssued;
          res_ticket_nxt = is_prio ? prio_ticket : reg_ticket;
          prio_cmd.push  = is_prio;
          reg_cmd.push   = !is_prio;
        end
      end else if (!prio_stat.empty) begin
        prio_cmd.pop   = 1'b1;
        res_status_nxt = tcpq_pkg::StServed;
        res_class_nxt  = tcpq_pkg::ClassPriority;
        res_pop_nxt    = 1'b1;
      end else if (!reg_stat.empty) begin
        reg_cmd.pop    = 1'b1;
        res_status_nxt = tcpq_pkg::StServed;
        res_class_nxt  = tcpq_pkg::ClassRegular;
        res_pop_nxt    = 1'b1;
      end else begin
        res_status_nxt = tcpq_pkg::StEmpty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      threshold_r <= tcpq_pkg::ThresholdReset;
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      if (cfg_we) begin
        threshold_r <= cfg_wdata;
      end
      req_valid_r <= start && !busy_r;
      res_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    req_type_r   <= in_req_type;
    req_age_r    <= in_client_age;
    req_tag_r    <= in_client_tag;
    res_status_r <= res_status_nxt;
    res_class_r  <= res_class_nxt;
    res_ticket_r <= res_ticket_nxt;
    res_tag_r    <= res_tag_nxt;
    res_pop_r    <= res_pop_nxt;
  end

  tcpq_class_queue #(
    .DEPTH   (QUEUE_DEPTH),
    .TICKETS (TICKETS_PER_CLASS)
  ) u_prio_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (prio_cmd),
    .push_tag   (req_tag_r),
    .stat       (prio_stat),
    .ticket     (prio_ticket),
    .pop_tag    (prio_pop_tag),
    .pop_ticket (prio_pop_ticket)
  );

  tcpq_class_queue #(
    .DEPTH   (QUEUE_DEPTH),
    .TICKETS (TICKETS_PER_CLASS)
  ) u_reg_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (reg_cmd),
    .push_tag   (req_tag_r),
    .stat       (reg_stat),
    .ticket     (reg_ticket),
    .pop_tag    (reg_pop_tag),
    .pop_ticket (reg_pop_ticket)
  );

  // On a served call the tag and ticket come from the RAM read register of
  // the class that was popped; other result fields come from the result register.
  assign busy              = busy_r;
  assign out_valid         = res_valid_r;
  assign out_status        = res_status_r;
  assign out_queue_class   = res_class_r;
  assign out_ticket_number = !res_pop_r ? res_ticket_r :
                             (res_class_r ? prio_pop_ticket : reg_pop_ticket);
  assign out_served_tag    = !res_pop_r ? res_tag_r :
                             (res_class_r ? prio_pop_tag : reg_pop_tag);

`ifndef SYNTHESIS
  a_one_queue_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !((prio_cmd.push || prio_cmd.pop) && (reg_cmd.push || reg_cmd.pop)))
    else $error("both class queues commanded in one cycle");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid_r |=> res_valid_r)
    else $error("request did not produce a result");

  a_regular_behind_priority: assert property (@(posedge clk) disable iff (!rst_n)
    reg_cmd.pop |-> prio_stat.empty)
    else $error("regular client served while priority clients wait");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tcpq_checker.sv =====
// ----------------------------------------------------------------------------
// tcpq_checker
// Watches the request and result channels of the two-class priority ticket
// queue. It keeps its own copy of both class FIFOs, the ticket counters and
// the age threshold, predicts one result per accepted request and compares
// every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcpq_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         in_req_type,
  input  logic [tcpq_pkg::AgeW-1:0]    in_client_age,
  input  logic [tcpq_pkg::TagW-1:0]    in_client_tag,
  input  logic                         out_valid,
  input  logic [tcpq_pkg::StatusW-1:0] out_status,
  input  logic                         out_queue_class,
  input  logic [3:0]                   out_ticket_number,
  input  logic [tcpq_pkg::TagW-1:0]    out_served_tag,
  input  logic                         cfg_we,
  input  logic [tcpq_pkg::AgeW-1:0]    cfg_wdata,
  output int                           fail_count,
  output int                           pending,
  output int                           results_checked,
  output int                           drops_seen,
  output int                           empties_seen
);

  localparam int QDepth  = tcpq_pkg::QueueDepthDefault;
  localparam int Tickets = tcpq_pkg::TicketsDefault;

  typedef struct packed {
    tcpq_pkg::status_t         status;
    logic                      queue_class;
    logic [3:0]                ticket;
    logic [tcpq_pkg::TagW-1:0] tag;
  } ticket_result_t;

  ticket_result_t   ticket_results_due[$];

  logic [tcpq_pkg::TagW-1:0] tag_store    [2][QDepth];
  logic [3:0]                ticket_store [2][QDepth];
  int                        head  [2];
  int                        tail  [2];
  int                        count [2];
  logic [3:0]                next_ticket [2];
  logic [tcpq_pkg::AgeW-1:0] age_threshold;

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    drops_seen      = 0;
    empties_seen    = 0;
  end

  task automatic clear_queues();
    for (int c = 0; c < 2; c++) begin
      head[c]        = 0;
      tail[c]        = 0;
      count[c]       = 0;
      next_ticket[c] = '0;
    end
    age_threshold = tcpq_pkg::ThresholdReset;
  endtask

  task automatic append_due(input ticket_result_t r);
    ticket_results_due = {ticket_results_due, r};
  endtask

  task automatic predict_ticket(input logic req, input logic [tcpq_pkg::AgeW-1:0] age,
                                input logic [tcpq_pkg::TagW-1:0] tag,
                                output ticket_result_t r);
    int c;
    r = '0;
    if (req == tcpq_pkg::ReqArrival) begin
      c = (age >= age_threshold) ? 1 : 0;
      r.queue_class = c[0];
      r.tag         = tag;
      if (count[c] >= QDepth) begin
        // The client is dropped and the class counter holds still.
        r.status = tcpq_pkg::StFull;
      end else begin
        r.status = tcpq_pkg::StIssued;
        r.ticket = next_ticket[c];
        next_ticket[c] = (int'(next_ticket[c]) + 1 >= Tickets) ? 4'd0 : next_ticket[c] + 4'd1;
        tag_store[c][tail[c]]    = tag;
        ticket_store[c][tail[c]] = r.ticket;
        tail[c]  = (tail[c] + 1) % QDepth;
        count[c] = count[c] + 1;
      end
    end else begin
      c = (count[1] != 0) ? 1 : 0;
      if (count[c] == 0) begin
        r.status = tcpq_pkg::StEmpty;
      end else begin
        r.status      = tcpq_pkg::StServed;
        r.queue_class = c[0];
        r.tag         = tag_store[c][head[c]];
        r.ticket      = ticket_store[c][head[c]];
        head[c]  = (head[c] + 1) % QDepth;
        count[c] = count[c] - 1;
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    ticket_result_t want;
    if (!rst_n) begin
      clear_queues();
      ticket_results_due.delete();
    end else begin
      if (out_valid) begin
        if (ticket_results_due.size() == 0) begin
          $display("%0t ns: result with no request outstanding, status %0d tag %h",
                   $time, out_status, out_served_tag);
          fail_count++;
        end else begin
          want = ticket_results_due.pop_front();
          check_field("status", want.status, out_status);
          check_field("queue_class", want.queue_class, out_queue_class);
          check_field("ticket_number", want.ticket, out_ticket_number);
          check_field("served_tag", want.tag, out_served_tag);
          results_checked++;
          if (want.status == tcpq_pkg::StFull) drops_seen++;
          if (want.status == tcpq_pkg::StEmpty) empties_seen++;
        end
      end
      if (start && !busy) begin
        predict_ticket(in_req_type, in_client_age, in_client_tag, want);
        append_due(want);
      end
      if (cfg_we) age_threshold = cfg_wdata;
    end
    pending = ticket_results_due.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the two-class priority ticket queue. Requests go
// out in bursts with random gaps; the age threshold is rewritten between
// phases once all results are in. Checking is done by tcpq_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int TicketW    = $clog2(tcpq_pkg::TicketsDefault);
  localparam int CycleLimit = 100000;
  localparam int PhaseItems = 85;
  localparam int AgeW       = tcpq_pkg::AgeW;
  localparam int TagW       = tcpq_pkg::TagW;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic                         in_req_type;
  logic [AgeW-1:0]              in_client_age;
  logic [TagW-1:0]              in_client_tag;
  logic                         out_valid;
  logic [tcpq_pkg::StatusW-1:0] out_status;
  logic                         out_queue_class;
  logic [TicketW-1:0]           out_ticket_number;
  logic [TagW-1:0]              out_served_tag;
  logic                         cfg_we;
  logic [AgeW-1:0]              cfg_wdata;

  int                  fail_count;
  int                  pending;
  int                  results_checked;
  int                  drops_seen;
  int                  empties_seen;
  int                  cycles = 0;
  logic                took = 1'b0;
  bit                  start_high = 1'b0;
  int                  burst_left = 1;
  int                  requests_sent = 0;
  logic [AgeW-1:0]     thr_now = tcpq_pkg::ThresholdReset;

  two_class_priority_ticket_queue i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_client_age     (in_client_age),
    .in_client_tag     (in_client_tag),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_queue_class   (out_queue_class),
    .out_ticket_number (out_ticket_number),
    .out_served_tag    (out_served_tag),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  tcpq_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_client_age     (in_client_age),
    .in_client_tag     (in_client_tag),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_queue_class   (out_queue_class),
    .out_ticket_number (out_ticket_number),
    .out_served_tag    (out_served_tag),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .pending           (pending),
    .results_checked   (results_checked),
    .drops_seen        (drops_seen),
    .empties_seen      (empties_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Records whether the edge just gone transferred a request; read at the
  // following falling edge.
  always @(posedge clk) took <= start && !busy;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("two_class_priority_ticket_queue test failed");
      $finish;
    end
  end

  task automatic release_start();
    if (start_high) begin
      start      <= 1'b0;
      start_high  = 1'b0;
    end
  endtask

  // Called at a falling edge; returns at a falling edge after the transfer.
  task automatic send_request(input logic req, input logic [AgeW-1:0] age,
                              input logic [TagW-1:0] tag);
    in_req_type   <= req;
    in_client_age <= age;
    in_client_tag <= tag;
    start         <= 1'b1;
    start_high     = 1'b1;
    @(negedge clk);
    while (!took) @(negedge clk);
    requests_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      // A quarter of the bursts are long stretches with no gaps at all.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
      if ($urandom_range(0, 4) != 0) begin
        release_start();
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  endtask

  task automatic write_threshold(input logic [AgeW-1:0] value);
    release_start();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    thr_now    = value;
  endtask

  function automatic logic [AgeW-1:0] pick_age();
    int a;
    if ($urandom_range(0, 1) == 0) begin
      a = $urandom_range(0, 127);
    end else begin
      // Straddle the threshold so both sides of the compare get exercised.
      a = int'(thr_now) + int'($urandom_range(0, 2)) - 1;
      if (a < 0) a = 0;
      if (a > 127) a = 127;
    end
    return a[AgeW-1:0];
  endfunction

  initial begin : stimulus
    logic [AgeW-1:0] phase_thr [6];
    int              arrival_pct;
    logic            req;
    int              mix;

    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_req_type   <= tcpq_pkg::ReqArrival;
    in_client_age <= '0;
    in_client_tag <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset threshold: empty call, the age and tag
    // extremes, both sides of the threshold, a regular class that fills up
    // through a ticket wrap and then drops, and calls served priority first.
    send_request(tcpq_pkg::ReqCall, 7'd0, 16'h0000);
    send_request(tcpq_pkg::ReqArrival, 7'd0, 16'h0000);
    send_request(tcpq_pkg::ReqArrival, 7'd127, 16'hFFFF);
    send_request(tcpq_pkg::ReqArrival, 7'd64, 16'h5A5A);
    send_request(tcpq_pkg::ReqArrival, 7'd65, 16'hA5A5);
    for (int i = 0; i < 15; i++) begin
      send_request(tcpq_pkg::ReqArrival, 7'($urandom_range(0, 64)), 16'($urandom));
    end
    for (int i = 0; i < 4; i++) begin
      send_request(tcpq_pkg::ReqCall, 7'($urandom), 16'($urandom));
    end

    phase_thr[0] = 7'd0;
    phase_thr[1] = 7'd127;
    phase_thr[2] = 7'd1;
    phase_thr[3] = 7'd126;
    phase_thr[4] = 7'($urandom);
    phase_thr[5] = 7'($urandom);

    arrival_pct = 50;
    for (int p = 0; p < 6; p++) begin
      write_threshold(phase_thr[p]);
      for (int k = 0; k < PhaseItems; k++) begin
        if (k % 20 == 0) begin
          // Segments lean toward filling, balancing or draining the queues.
          mix = $urandom_range(0, 2);
          arrival_pct = (mix == 0) ? 15 : (mix == 1) ? 50 : 90;
        end
        req = ($urandom_range(0, 99) < arrival_pct) ? tcpq_pkg::ReqArrival
                                                    : tcpq_pkg::ReqCall;
        send_request(req, pick_age(), 16'($urandom));
      end
    end

    release_start();
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d requests over 7 threshold settings; checked %0d results,",
             requests_sent, results_checked);
    $display("  %0d of them full-queue drops and %0d empty calls.", drops_seen, empties_seen);
    if (fail_count == 0) begin
      $display("two_class_priority_ticket_queue test passed");
    end else begin
      $display("two_class_priority_ticket_queue test failed");
    end
    $finish;
  end

endmodule
